// ===== rtl/cvcd_pkg.sv =====
// Shared widths, register codes and inter-module types for the CUSUM variance detector.
`timescale 1ns / 1ps

package cvcd_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int TICK_W     = 32;
    localparam int GAIN_W     = 24;
    localparam int SCORE_W    = 32;
    localparam int SQ_W       = 31;                  // x^2 <= 2^30
    localparam int PROD_W     = GAIN_W + SQ_W;       // signed gain * sq
    localparam int FRAC_DROP  = 16;
    localparam int TERM_W     = PROD_W - FRAC_DROP;  // Q16.16 term after floor
    localparam int SUM_W      = TERM_W + 2;          // acc + term - offset
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 40;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = 2;
    localparam int FIFO_CNT_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_QUAD_GAIN       = 3'd0,
        REG_SCORE_OFFSET    = 3'd1,
        REG_ALARM_THRESHOLD = 3'd2,
        REG_CONFIRM_WINDOW  = 3'd3,
        REG_ENABLE_TIME     = 3'd4
    } cvcd_reg_t;

    // one classified sample as it waits between front and back
    typedef struct packed {
        logic                     skip;     // before enable time
        logic [TICK_W-1:0]        now_tick;
        logic [TERM_W-1:0]        term;     // signed, floor(gain*x^2 >> 16)
    } cvcd_item_t;

    typedef struct packed {
        logic [SCORE_W-1:0] score_offset;   // signed
        logic [SCORE_W-1:0] alarm_threshold;
        logic [TICK_W-1:0]  confirm_window;
    } cvcd_cfg_t;

endpackage

// ===== rtl/cusum_variance_change_detector_unit.sv =====
// Top level of the CUSUM variance change detector: register file and datapath wiring.
`timescale 1ns / 1ps

// Takes one sample per clock while s_axis_tready is high and returns one result per sample,
// in order. A sample passes three front-end stages (input register with the enable check,
// x^2, gain multiply), is written to a four-entry queue, and is scored by the accumulator,
// whose feedback loop sustains one item per clock while m_axis_tready does not stall it.
// The accumulator stalls on m_axis_tready alone; the front end keeps taking samples until
// the queue fills. Registers (cfg_index):
// 0 quad_gain, 1 score_offset, 2 alarm_threshold, 3 confirm_window, 4 enable_time;
// other indexes are ignored. cfg_ready is always high. Write registers only while idle.
module cusum_variance_change_detector_unit (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [cvcd_pkg::IN_DATA_W-1:0]      s_axis_tdata,  // sample[15:0], now_tick[47:16]
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [cvcd_pkg::OUT_DATA_W-1:0]     m_axis_tdata,  // alarm[0], score[32:1]
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [cvcd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [cvcd_pkg::CFG_DATA_W-1:0]     cfg_data
);

    logic [cvcd_pkg::GAIN_W-1:0]  quad_gain_reg;
    logic [cvcd_pkg::SCORE_W-1:0] score_offset_reg;
    logic [cvcd_pkg::SCORE_W-1:0] alarm_threshold_reg;
    logic [cvcd_pkg::TICK_W-1:0]  confirm_window_reg;
    logic [cvcd_pkg::TICK_W-1:0]  enable_time_reg;

    cvcd_pkg::cvcd_cfg_t  back_cfg;
    cvcd_pkg::cvcd_item_t fifo_wdata, fifo_rdata;
    logic                 fifo_full, fifo_push, fifo_pop, fifo_rvalid;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            quad_gain_reg       <= '0;
            score_offset_reg    <= '0;
            alarm_threshold_reg <= '0;
            confirm_window_reg  <= '0;
            enable_time_reg     <= '0;
        end else if (cfg_valid && cfg_ready) begin
            case (cvcd_pkg::cvcd_reg_t'(cfg_index))
                cvcd_pkg::REG_QUAD_GAIN: begin
                    quad_gain_reg <= cfg_data[cvcd_pkg::GAIN_W-1:0];
                end
                cvcd_pkg::REG_SCORE_OFFSET: begin
                    score_offset_reg <= cfg_data;
                end
                cvcd_pkg::REG_ALARM_THRESHOLD: begin
                    alarm_threshold_reg <= cfg_data;
                end
                cvcd_pkg::REG_CONFIRM_WINDOW: begin
                    confirm_window_reg <= cfg_data;
                end
                cvcd_pkg::REG_ENABLE_TIME: begin
                    enable_time_reg <= cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        back_cfg.score_offset    = score_offset_reg;
        back_cfg.alarm_threshold = alarm_threshold_reg;
        back_cfg.confirm_window  = confirm_window_reg;
    end

    cvcd_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .quad_gain     (quad_gain_reg),
        .enable_time   (enable_time_reg),
        .fifo_full     (fifo_full),
        .fifo_push     (fifo_push),
        .fifo_wdata    (fifo_wdata)
    );

    cvcd_fifo u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (fifo_push),
        .wdata   (fifo_wdata),
        .full    (fifo_full),
        .pop     (fifo_pop),
        .rvalid  (fifo_rvalid),
        .rdata   (fifo_rdata)
    );

    cvcd_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg           (back_cfg),
        .item_valid    (fifo_rvalid),
        .item          (fifo_rdata),
        .item_pop      (fifo_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule

// ===== rtl/cvcd_front.sv =====
// Front end: accepts samples, flags pre-enable samples, forms the gain*x^2 term.
`timescale 1ns / 1ps

module cvcd_front (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [cvcd_pkg::IN_DATA_W-1:0]      s_axis_tdata,  // sample[15:0], now_tick[47:16]
    input  logic [cvcd_pkg::GAIN_W-1:0]         quad_gain,
    input  logic [cvcd_pkg::TICK_W-1:0]         enable_time,
    input  logic                                fifo_full,
    output logic                                fifo_push,
    output cvcd_pkg::cvcd_item_t                fifo_wdata
);

    logic                            advance;
    logic [cvcd_pkg::SAMPLE_W-1:0]   sample;
    logic [cvcd_pkg::TICK_W-1:0]     now_tick;
    logic                            skip_next;
    logic [2*cvcd_pkg::SAMPLE_W-1:0] x_ext;
    logic [2*cvcd_pkg::SAMPLE_W-1:0] sq_full;
    logic [cvcd_pkg::PROD_W-1:0]     prod;

    logic                            v1_reg, v2_reg, v3_reg;
    logic                            skip1_reg, skip2_reg, skip3_reg;
    logic [cvcd_pkg::TICK_W-1:0]     now1_reg, now2_reg, now3_reg;
    logic [cvcd_pkg::SAMPLE_W-1:0]   x1_reg;
    logic [cvcd_pkg::SQ_W-1:0]       sq2_reg;
    logic [cvcd_pkg::TERM_W-1:0]     term3_reg;

    always_comb begin
        advance       = !(v3_reg && fifo_full);
        s_axis_tready = advance;
        sample        = s_axis_tdata[cvcd_pkg::SAMPLE_W-1:0];
        now_tick      = s_axis_tdata[cvcd_pkg::SAMPLE_W +: cvcd_pkg::TICK_W];
        skip_next     = enable_time > now_tick;
        x_ext         = {{cvcd_pkg::SAMPLE_W{x1_reg[cvcd_pkg::SAMPLE_W-1]}}, x1_reg};
        sq_full       = x_ext * x_ext;
        // signed 24 x 32 multiply, x^2 is never negative
        prod          = cvcd_pkg::PROD_W'($signed(quad_gain) * $signed({1'b0, sq2_reg}));
        fifo_push     = advance && v3_reg;
        fifo_wdata.skip     = skip3_reg;
        fifo_wdata.now_tick = now3_reg;
        fifo_wdata.term     = term3_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (advance) begin
            v1_reg <= s_axis_tvalid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            x1_reg    <= sample;
            now1_reg  <= now_tick;
            skip1_reg <= skip_next;
            sq2_reg   <= sq_full[cvcd_pkg::SQ_W-1:0];
            now2_reg  <= now1_reg;
            skip2_reg <= skip1_reg;
            // dropping low bits of a two's complement value is a floor
            term3_reg <= prod[cvcd_pkg::PROD_W-1:cvcd_pkg::FRAC_DROP];
            now3_reg  <= now2_reg;
            skip3_reg <= skip2_reg;
        end
    end

endmodule

// ===== rtl/cvcd_fifo.sv =====
// Short queue between the front end and the accumulator.
`timescale 1ns / 1ps

module cvcd_fifo (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push,
    input  cvcd_pkg::cvcd_item_t wdata,
    output logic                 full,
    input  logic                 pop,
    output logic                 rvalid,
    output cvcd_pkg::cvcd_item_t rdata
);

    cvcd_pkg::cvcd_item_t                mem_reg [cvcd_pkg::FIFO_DEPTH];
    logic [cvcd_pkg::FIFO_PTR_W-1:0]     wr_ptr_reg, rd_ptr_reg;
    logic [cvcd_pkg::FIFO_CNT_W-1:0]     count_reg, count_next;

    always_comb begin
        full   = count_reg == cvcd_pkg::FIFO_CNT_W'(cvcd_pkg::FIFO_DEPTH);
        rvalid = count_reg != '0;
        rdata  = mem_reg[rd_ptr_reg];
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

// ===== rtl/cvcd_back.sv =====
// Back end: score accumulate with clamp, threshold crossing and confirm logic.
`timescale 1ns / 1ps

module cvcd_back (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  cvcd_pkg::cvcd_cfg_t               cfg,
    input  logic                              item_valid,
    input  cvcd_pkg::cvcd_item_t              item,
    output logic                              item_pop,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [cvcd_pkg::OUT_DATA_W-1:0]   m_axis_tdata   // alarm[0], score[32:1]
);

    logic [cvcd_pkg::SCORE_W-1:0] score_acc_reg, score_acc_next;
    logic                         pending_valid_reg, pending_valid_next;
    logic [cvcd_pkg::TICK_W-1:0]  pending_time_reg, pending_time_next;
    logic                         m_valid_reg, m_valid_next;
    logic                         alarm_reg, alarm_next;
    logic [cvcd_pkg::SCORE_W-1:0] score_reg, score_next;

    logic [cvcd_pkg::SUM_W-1:0]   sum;
    logic [cvcd_pkg::SCORE_W-1:0] clamped;
    logic [cvcd_pkg::TICK_W-1:0]  delta;

    always_comb begin
        item_pop = item_valid && (!m_valid_reg || m_axis_tready);
        sum = {{(cvcd_pkg::SUM_W-cvcd_pkg::SCORE_W){1'b0}}, score_acc_reg}
            + {{(cvcd_pkg::SUM_W-cvcd_pkg::TERM_W){item.term[cvcd_pkg::TERM_W-1]}}, item.term}
            - {{(cvcd_pkg::SUM_W-cvcd_pkg::SCORE_W){cfg.score_offset[cvcd_pkg::SCORE_W-1]}},
               cfg.score_offset};
        if (sum[cvcd_pkg::SUM_W-1]) begin
            clamped = '0;
        end else if (sum[cvcd_pkg::SUM_W-2:cvcd_pkg::SCORE_W] != '0) begin
            clamped = '1;
        end else begin
            clamped = sum[cvcd_pkg::SCORE_W-1:0];
        end
        delta = item.now_tick - pending_time_reg;   // wraps on backward time

        score_acc_next     = score_acc_reg;
        pending_valid_next = pending_valid_reg;
        pending_time_next  = pending_time_reg;
        alarm_next         = alarm_reg;
        score_next         = score_reg;
        m_valid_next       = m_valid_reg && !m_axis_tready;

        if (item_pop) begin
            m_valid_next = 1'b1;
            alarm_next   = 1'b0;
            score_next   = '0;
            if (!item.skip) begin
                score_acc_next = clamped;
                score_next     = clamped;
                if (clamped > cfg.alarm_threshold) begin
                    score_acc_next = '0;
                    score_next     = cfg.alarm_threshold;
                    if (cfg.confirm_window == '0) begin
                        alarm_next = 1'b1;
                    end else if (!pending_valid_reg) begin
                        pending_valid_next = 1'b1;
                        pending_time_next  = item.now_tick;
                    end else if (delta <= cfg.confirm_window) begin
                        pending_valid_next = 1'b0;
                        pending_time_next  = '0;
                        alarm_next         = 1'b1;
                    end else begin
                        pending_time_next = item.now_tick;
                    end
                end
            end
        end

        m_axis_tvalid = m_valid_reg;
        m_axis_tdata  = {{(cvcd_pkg::OUT_DATA_W-cvcd_pkg::SCORE_W-1){1'b0}}, score_reg, alarm_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            score_acc_reg     <= '0;
            pending_valid_reg <= 1'b0;
            pending_time_reg  <= '0;
            m_valid_reg       <= 1'b0;
        end else begin
            score_acc_reg     <= score_acc_next;
            pending_valid_reg <= pending_valid_next;
            pending_time_reg  <= pending_time_next;
            m_valid_reg       <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        alarm_reg <= alarm_next;
        score_reg <= score_next;
    end

endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for the CUSUM variance change detector unit.
`timescale 1ns / 1ps

module testbench;

    localparam int CLK_HALF      = 10;
    localparam int RESET_CYCLES  = 12;
    localparam int SETTLE_CYCLES = 8;    // pipeline drain margin before a register write
    localparam int HOLD_CYCLES   = 60;   // long output stall, fills queue and front end
    localparam int PHASES        = 12;
    localparam int PHASE_ITEMS   = 160;

    typedef struct packed {
        logic                         alarm;
        logic [cvcd_pkg::SCORE_W-1:0] score;
    } detect_t;

    typedef enum logic [1:0] {
        ROW_WRITE,    // register write: idx, value
        ROW_PREDICT,  // sample checked against the predictor
        ROW_TYPED     // sample with its result written out in the row
    } row_kind_t;

    typedef struct packed {
        row_kind_t                      kind;
        logic [cvcd_pkg::CFG_IDX_W-1:0] idx;
        logic [cvcd_pkg::TICK_W-1:0]    value;  // register data or now_tick
        logic [cvcd_pkg::SAMPLE_W-1:0]  x;
        logic                           alarm;
        logic [cvcd_pkg::SCORE_W-1:0]   score;
    } plan_row_t;

    logic                              aclk = 1'b0;
    logic                              aresetn = 1'b0;
    logic                              s_axis_tvalid = 1'b0;
    logic                              s_axis_tready;
    logic [cvcd_pkg::IN_DATA_W-1:0]    s_axis_tdata = '0;   // sample[15:0], now_tick[47:16]
    logic                              m_axis_tvalid;
    logic                              m_axis_tready = 1'b0;
    logic [cvcd_pkg::OUT_DATA_W-1:0]   m_axis_tdata;        // alarm[0], score[32:1]
    logic                              cfg_valid = 1'b0;
    logic                              cfg_ready;
    logic [cvcd_pkg::CFG_IDX_W-1:0]    cfg_index = '0;
    logic [cvcd_pkg::CFG_DATA_W-1:0]   cfg_data = '0;

    // predictor copy of registers and detector state
    logic signed [cvcd_pkg::GAIN_W-1:0]  cfg_gain = '0;
    logic signed [cvcd_pkg::SCORE_W-1:0] cfg_offset = '0;
    logic [cvcd_pkg::SCORE_W-1:0]        cfg_threshold = '0;
    logic [cvcd_pkg::TICK_W-1:0]         cfg_window = '0;
    logic [cvcd_pkg::TICK_W-1:0]         cfg_enable = '0;
    logic [cvcd_pkg::SCORE_W-1:0]        cusum_acc = '0;
    logic                                first_cross_seen = 1'b0;
    logic [cvcd_pkg::TICK_W-1:0]         first_cross_tick = '0;

    detect_t   results_due [$];
    plan_row_t plan [$];
    int        mismatch_count = 0;
    bit        idle_on = 1'b1;
    bit        hold_request = 1'b0;

    cusum_variance_change_detector_unit DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always begin
        #CLK_HALF aclk = 1'b1;
        #CLK_HALF aclk = 1'b0;
    end

    initial begin
        #4ms;
        $display("Test completed with failures");
        $finish;
    end

    function automatic plan_row_t wr(input logic [cvcd_pkg::CFG_IDX_W-1:0] idx,
                                     input logic [cvcd_pkg::CFG_DATA_W-1:0] val);
        return '{ROW_WRITE, idx, val, '0, 1'b0, '0};
    endfunction

    function automatic plan_row_t smp(input logic [cvcd_pkg::SAMPLE_W-1:0] x,
                                      input logic [cvcd_pkg::TICK_W-1:0] tick);
        return '{ROW_PREDICT, '0, tick, x, 1'b0, '0};
    endfunction

    function automatic plan_row_t chk(input logic [cvcd_pkg::SAMPLE_W-1:0] x,
                                      input logic [cvcd_pkg::TICK_W-1:0] tick,
                                      input logic alarm,
                                      input logic [cvcd_pkg::SCORE_W-1:0] score);
        return '{ROW_TYPED, '0, tick, x, alarm, score};
    endfunction

    // one CUSUM step: score update, crossing and confirmation logic
    function automatic detect_t cusum_update(input logic signed [cvcd_pkg::SAMPLE_W-1:0] x,
                                             input logic [cvcd_pkg::TICK_W-1:0] tick);
        longint  sq;
        longint  term;
        longint  sum;
        detect_t r;
        r = '0;
        if (cfg_enable > tick)
            return r;
        sq   = longint'(x) * longint'(x);
        term = (longint'(cfg_gain) * sq) >>> cvcd_pkg::FRAC_DROP;   // floor
        sum  = longint'({32'b0, cusum_acc}) + term - longint'(cfg_offset);
        if (sum < 0)
            sum = 0;
        if (sum > longint'(64'hFFFF_FFFF))
            sum = longint'(64'hFFFF_FFFF);
        cusum_acc = sum[cvcd_pkg::SCORE_W-1:0];
        r.score   = cusum_acc;
        if (cusum_acc > cfg_threshold) begin
            if (cfg_window == '0) begin
                r.alarm = 1'b1;
            end else if (!first_cross_seen) begin
                first_cross_seen = 1'b1;
                first_cross_tick = tick;
            end else if (cvcd_pkg::TICK_W'(tick - first_cross_tick) <= cfg_window) begin
                first_cross_seen = 1'b0;
                first_cross_tick = '0;
                r.alarm = 1'b1;
            end else begin
                first_cross_tick = tick;
            end
            cusum_acc = '0;
            r.score   = cfg_threshold;
        end
        return r;
    endfunction

    task automatic note_mismatch(input string what,
                                 input logic [cvcd_pkg::SCORE_W-1:0] got,
                                 input logic [cvcd_pkg::SCORE_W-1:0] want);
        $display("%0t: %s mismatch: got %h expected %h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    task automatic write_reg(input logic [cvcd_pkg::CFG_IDX_W-1:0] idx,
                             input logic [cvcd_pkg::CFG_DATA_W-1:0] val);
        s_axis_tvalid <= 1'b0;
        while (results_due.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            cvcd_pkg::REG_QUAD_GAIN:       cfg_gain      = val[cvcd_pkg::GAIN_W-1:0];
            cvcd_pkg::REG_SCORE_OFFSET:    cfg_offset    = val;
            cvcd_pkg::REG_ALARM_THRESHOLD: cfg_threshold = val;
            cvcd_pkg::REG_CONFIRM_WINDOW:  cfg_window    = val;
            cvcd_pkg::REG_ENABLE_TIME:     cfg_enable    = val;
            default: ;
        endcase
    endtask

    task automatic send_sample(input logic [cvcd_pkg::SAMPLE_W-1:0] x,
                               input logic [cvcd_pkg::TICK_W-1:0] tick,
                               input bit typed, input detect_t want);
        detect_t predicted;
        if (idle_on && $urandom_range(0, 5) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {tick, x};
        do @(posedge aclk); while (!s_axis_tready);
        predicted = cusum_update(x, tick);
        results_due.push_back(typed ? want : predicted);
    endtask

    // result side: random stalls, plus one long hold-off on request
    initial begin : result_sink
        forever begin
            @(posedge aclk);
            if (hold_request) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_request = 1'b0;
                m_axis_tready <= 1'b1;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge aclk);
                m_axis_tready <= 1'b1;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        detect_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (results_due.size() == 0) begin
                note_mismatch("unexpected result", m_axis_tdata[32:1], '0);
            end else begin
                want = results_due.pop_front();
                if (m_axis_tdata[0] !== want.alarm)
                    note_mismatch("alarm", cvcd_pkg::SCORE_W'(m_axis_tdata[0]),
                                  cvcd_pkg::SCORE_W'(want.alarm));
                if (m_axis_tdata[32:1] !== want.score)
                    note_mismatch("score", m_axis_tdata[32:1], want.score);
            end
        end
    end

    initial begin : stimulus
        logic [cvcd_pkg::TICK_W-1:0]   tick_now;
        logic [cvcd_pkg::SAMPLE_W-1:0] x;
        int                            kind;

        plan = '{
            // reset registers: score stays at zero
            chk(16'h7FFF, 32'h0000_0000, 1'b0, 32'h0),
            chk(16'h8000, 32'hFFFF_FFFF, 1'b0, 32'h0),
            // largest gain, most negative offset: score saturates
            wr(cvcd_pkg::REG_QUAD_GAIN, 32'h007F_FFFF),
            wr(cvcd_pkg::REG_SCORE_OFFSET, 32'h8000_0000),
            wr(cvcd_pkg::REG_ALARM_THRESHOLD, 32'hFFFF_FFFF),
            chk(16'h8000, 32'd1, 1'b0, 32'hFFFF_FFFF),
            chk(16'h0000, 32'd2, 1'b0, 32'hFFFF_FFFF),
            // most negative gain, largest offset: clamped at zero
            wr(cvcd_pkg::REG_QUAD_GAIN, 32'h0080_0000),
            wr(cvcd_pkg::REG_SCORE_OFFSET, 32'h7FFF_FFFF),
            chk(16'h8000, 32'd3, 1'b0, 32'h0),
            // gain -1 LSB: floor rounding of a tiny negative term
            wr(cvcd_pkg::REG_QUAD_GAIN, 32'h00FF_FFFF),
            wr(cvcd_pkg::REG_SCORE_OFFSET, 32'hFFFF_0000),
            smp(16'h0001, 32'd5),
            smp(16'hFFFF, 32'd6),
            // crossing with immediate alarm
            wr(cvcd_pkg::REG_QUAD_GAIN, 32'h0),
            wr(cvcd_pkg::REG_ALARM_THRESHOLD, 32'h0001_8000),
            smp(16'h0000, 32'd7),
            // every sample crosses from here: confirm window of 10 ticks
            wr(cvcd_pkg::REG_ALARM_THRESHOLD, 32'h0),
            wr(cvcd_pkg::REG_SCORE_OFFSET, 32'hFFFF_FFFF),
            wr(cvcd_pkg::REG_CONFIRM_WINDOW, 32'd10),
            smp(16'h0000, 32'd100),
            smp(16'h0000, 32'd110),
            smp(16'h0000, 32'd200),
            smp(16'h0000, 32'd211),
            smp(16'h0000, 32'd221),
            smp(16'h0000, 32'd300),
            smp(16'h0000, 32'd299),   // time runs backwards: stale
            smp(16'h0000, 32'd299),
            // immediate mode leaves the remembered crossing alone
            smp(16'h0000, 32'd400),
            wr(cvcd_pkg::REG_CONFIRM_WINDOW, 32'h0),
            smp(16'h0000, 32'd401),
            wr(cvcd_pkg::REG_CONFIRM_WINDOW, 32'd10),
            smp(16'h0000, 32'd405),
            // widest window: even a wrapped difference confirms
            wr(cvcd_pkg::REG_CONFIRM_WINDOW, 32'hFFFF_FFFF),
            smp(16'h0000, 32'd7),
            smp(16'h0000, 32'd6),
            // enable time
            wr(cvcd_pkg::REG_ENABLE_TIME, 32'd1000),
            chk(16'h7FFF, 32'd999, 1'b0, 32'h0),
            smp(16'h0000, 32'd1000),
            wr(cvcd_pkg::REG_ENABLE_TIME, 32'hFFFF_FFFF),
            chk(16'h8000, 32'hFFFF_FFFE, 1'b0, 32'h0),
            smp(16'h0000, 32'hFFFF_FFFF),
            // unused indexes must not disturb anything
            wr(cvcd_pkg::CFG_IDX_W'(int'(cvcd_pkg::REG_ENABLE_TIME) + 1), 32'hFFFF_FFFF),
            wr(cvcd_pkg::CFG_IDX_W'(int'(cvcd_pkg::REG_ENABLE_TIME) + 2), 32'hFFFF_FFFF),
            wr(cvcd_pkg::CFG_IDX_W'(int'(cvcd_pkg::REG_ENABLE_TIME) + 3), 32'hFFFF_FFFF),
            smp(16'h0000, 32'hFFFF_FFFF)
        };

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (plan[i]) begin
            case (plan[i].kind)
                ROW_WRITE:   write_reg(plan[i].idx, plan[i].value);
                ROW_PREDICT: send_sample(plan[i].x, plan[i].value, 1'b0, '0);
                default:     send_sample(plan[i].x, plan[i].value, 1'b1,
                                         '{plan[i].alarm, plan[i].score});
            endcase
        end

        tick_now = $urandom_range(0, 32'h0010_0000);
        for (int phase = 0; phase < PHASES; phase++) begin
            kind = phase % 4;
            if (kind == 3) begin
                write_reg(cvcd_pkg::REG_QUAD_GAIN, $urandom);
                write_reg(cvcd_pkg::REG_SCORE_OFFSET, $urandom);
                write_reg(cvcd_pkg::REG_ALARM_THRESHOLD, $urandom);
                write_reg(cvcd_pkg::REG_CONFIRM_WINDOW, $urandom);
                write_reg(cvcd_pkg::REG_ENABLE_TIME, $urandom);
            end else begin
                write_reg(cvcd_pkg::REG_QUAD_GAIN,
                          $urandom_range(32'h0000_4000, 32'h0003_0000));
                write_reg(cvcd_pkg::REG_SCORE_OFFSET,
                          $urandom_range(0, 32'h0001_8000) - 32'h8000);
                write_reg(cvcd_pkg::REG_ALARM_THRESHOLD,
                          $urandom_range(32'h0001_0000, 32'h0020_0000));
                write_reg(cvcd_pkg::REG_CONFIRM_WINDOW,
                          (kind == 0) ? 32'h0 : $urandom_range(1, 40));
                write_reg(cvcd_pkg::REG_ENABLE_TIME,
                          (kind == 2) ? tick_now + $urandom_range(0, 200) : 32'h0);
            end
            idle_on = !(phase == 1 || phase >= PHASES - 2);

            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (phase == 2 && n == 0)
                    hold_request = 1'b1;
                if (phase == 5 && n == PHASE_ITEMS / 2) begin
                    s_axis_tvalid <= 1'b0;
                    while (results_due.size() != 0)
                        @(posedge aclk);
                end
                if ($urandom_range(0, 7) == 0) begin
                    x = cvcd_pkg::SAMPLE_W'($urandom);
                end else begin
                    x = cvcd_pkg::SAMPLE_W'($urandom_range(0, 16'h0300));
                    if ($urandom_range(0, 1))
                        x = -x;
                end
                if ($urandom_range(0, 31) == 0)
                    tick_now = $urandom;
                else
                    tick_now = tick_now + $urandom_range(0, 6);
                send_sample(x, tick_now, 1'b0, '0);
            end
        end

        s_axis_tvalid <= 1'b0;
        while (results_due.size() != 0)
            @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (mismatch_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
